@@ rtl/core/spoke_order_assigner_core_assert.svh @@
// Assertion macros for the spoke order assigner core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SPOKE_ORDER_ASSIGNER_CORE_ASSERT_SVH
`define SPOKE_ORDER_ASSIGNER_CORE_ASSERT_SVH

// same-cycle implication
`define SOA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SOA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/soa_pkg.sv @@
// Shared types and constants of the spoke order assigner.
// No dependencies.
package soa_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int LABELS           = 4096;
  localparam int LBL_W            = 12;
  localparam int POS_W            = 13;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] REG_GIANT     = 2'd0;
  localparam logic [1:0] REG_SPOKE_END = 2'd1;
  localparam logic [1:0] REG_VCOUNT    = 2'd2;

  localparam logic [LBL_W-1:0] GIANT_RST     = '0;
  localparam logic [POS_W-1:0] SPOKE_END_RST = 13'd4096;
  localparam logic [POS_W-1:0] VCOUNT_RST    = 13'd4096;

  typedef struct packed {
    logic             kind;
    logic [LBL_W-1:0] vertex_index;
    logic [LBL_W-1:0] vertex_label;
    logic             already_assigned;
  } in_req_t;

  typedef struct packed {
    logic             placed;
    logic [LBL_W-1:0] slot;
    logic [POS_W-1:0] new_spoke_end;
    logic             underflow;
  } out_rsp_t;

  typedef struct packed {
    logic [LBL_W-1:0] giant;
    logic [POS_W-1:0] end_base;
    logic [POS_W-1:0] vcount;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic order_valid;
  } stat_t;

endpackage

@@ rtl/core/soa_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/soa_engine.sv @@
// Vertex stores, spoke table rebuild sequencer and query lookup.
// Depends on soa_pkg and soa_ram.
module soa_engine #(
  parameter int MAX_VERTICES = soa_pkg::MAX_VERTICES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  soa_pkg::in_req_t in_req,
  input  soa_pkg::cfg_t    cfg,
  input  logic             cfg_wr,
  input  logic             out_hold,
  output logic             res_vld,
  output soa_pkg::out_rsp_t res,
  output soa_pkg::stat_t   stat
);
  import soa_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int SW   = $clog2(MAX_VERTICES + 1);
  localparam int CLRN = (MAX_VERTICES + 1 > LABELS) ? MAX_VERTICES + 1 : LABELS;
  localparam int KW   = $clog2(CLRN + 1);

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001, S_CLR   = 20'h00002, S_P1_RD = 20'h00004, S_P1_WT = 20'h00008,
    S_P1_SZ = 20'h00010, S_P2_RD = 20'h00020, S_P2_WT = 20'h00040, S_P2_HW = 20'h00080,
    S_P3_RD = 20'h00100, S_P3_WT = 20'h00200, S_P4_RD = 20'h00400, S_P4_WT = 20'h00800,
    S_P4_SZ = 20'h01000, S_P4_HW = 20'h02000, S_FIN   = 20'h04000, S_Q_RD  = 20'h08000,
    S_Q_WT  = 20'h10000, S_Q_OF  = 20'h20000, S_Q_OUT = 20'h40000, S_SPARE = 20'h80000
  } state_t;

  state_t            state_r, state_nxt;
  logic [KW-1:0]     cnt_r, cnt_nxt;
  logic [KW-1:0]     qidx_r, qidx_nxt;
  logic [LBL_W-1:0]  lab_r, lab_nxt;
  logic [SW-1:0]     k_r, k_nxt;
  logic [SW-1:0]     acc_r, acc_nxt;
  logic [LBL_W-1:0]  rank_r, rank_nxt;
  logic [POS_W-1:0]  end_r, end_nxt;
  logic              under_r, under_nxt;
  logic              ov_r, ov_nxt;
  out_rsp_t          res_r, res_nxt;

  logic              l_we;
  logic [VW-1:0]     l_wa, l_ra;
  logic [LBL_W:0]    l_wd, l_rd;
  logic              r_we;
  logic [VW-1:0]     r_wa, r_ra;
  logic [LBL_W-1:0]  r_wd, r_rd;
  logic              s_we;
  logic [LBL_W-1:0]  s_wa, s_ra;
  logic [SW-1:0]     s_wd, s_rd;
  logic              h_we;
  logic [SW-1:0]     h_wa, h_ra;
  logic [SW-1:0]     h_wd, h_rd;
  logic              o_we;
  logic [LBL_W-1:0]  o_wa, o_ra;
  logic [LBL_W-1:0]  o_wd, o_rd;

  logic [KW-1:0]     vc_w, n_w, idx_w, cnt_inc;
  logic              elig;
  logic              in_acc;

  soa_ram #(.WIDTH(LBL_W + 1), .DEPTH(MAX_VERTICES)) u_lbl (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
  soa_ram #(.WIDTH(LBL_W), .DEPTH(MAX_VERTICES)) u_rank (
    .clk(clk), .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));
  soa_ram #(.WIDTH(SW), .DEPTH(LABELS)) u_size (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  soa_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES + 1)) u_hist (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  soa_ram #(.WIDTH(LBL_W), .DEPTH(LABELS)) u_off (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  assign vc_w    = KW'(cfg.vcount);
  assign n_w     = (vc_w > KW'(MAX_VERTICES)) ? KW'(MAX_VERTICES) : vc_w;
  assign idx_w   = KW'(in_req.vertex_index);
  assign cnt_inc = cnt_r + KW'(1);
  assign elig    = !l_rd[LBL_W] && (l_rd[LBL_W-1:0] != cfg.giant);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc  = in_valid && !in_stall;
  assign res_vld = (state_r == S_Q_OUT) && !out_hold;
  assign res     = res_r;
  assign stat    = '{busy: (state_r != S_IDLE), order_valid: ov_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    qidx_nxt  = qidx_r;
    lab_nxt   = lab_r;
    k_nxt     = k_r;
    acc_nxt   = acc_r;
    rank_nxt  = rank_r;
    end_nxt   = end_r;
    under_nxt = under_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    l_we = 1'b0; l_wa = idx_w[VW-1:0]; l_ra = cnt_r[VW-1:0];
    l_wd = {in_req.already_assigned, in_req.vertex_label};
    r_we = 1'b0; r_wa = cnt_r[VW-1:0]; r_ra = cnt_r[VW-1:0]; r_wd = 12'(s_rd);
    s_we = 1'b0; s_wa = cnt_r[LBL_W-1:0]; s_ra = cnt_r[LBL_W-1:0]; s_wd = '0;
    h_we = 1'b0; h_wa = cnt_r[SW-1:0]; h_ra = cnt_r[SW-1:0]; h_wd = '0;
    o_we = 1'b0; o_wa = lab_r; o_ra = l_rd[LBL_W-1:0]; o_wd = 12'(h_rd);
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_req.kind == KIND_LOAD) begin
            l_we   = (idx_w < KW'(MAX_VERTICES));
            ov_nxt = 1'b0;
          end else begin
            qidx_nxt  = idx_w;
            cnt_nxt   = '0;
            state_nxt = ov_r ? S_Q_RD : S_CLR;
          end
        end
      end
      S_CLR: begin
        s_we = (cnt_r < KW'(LABELS));
        h_we = (cnt_r <= KW'(MAX_VERTICES));
        cnt_nxt = cnt_inc;
        if (cnt_r == KW'(CLRN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (n_w != '0) ? S_P1_RD : S_P2_RD;
        end
      end
      S_P1_RD: state_nxt = S_P1_WT;
      S_P1_WT: begin
        lab_nxt = l_rd[LBL_W-1:0];
        s_ra    = l_rd[LBL_W-1:0];
        if (elig) begin
          state_nxt = S_P1_SZ;
        end else begin
          cnt_nxt   = (cnt_inc == n_w) ? '0 : cnt_inc;
          state_nxt = (cnt_inc == n_w) ? S_P2_RD : S_P1_RD;
        end
      end
      S_P1_SZ: begin
        r_we = 1'b1;
        s_we = 1'b1;
        s_wa = lab_r;
        s_wd = SW'(s_rd + SW'(1));
        cnt_nxt   = (cnt_inc == n_w) ? '0 : cnt_inc;
        state_nxt = (cnt_inc == n_w) ? S_P2_RD : S_P1_RD;
      end
      S_P2_RD: state_nxt = S_P2_WT;
      S_P2_WT: begin
        k_nxt = s_rd;
        h_ra  = s_rd;
        if (s_rd != '0) begin
          state_nxt = S_P2_HW;
        end else if (cnt_r[LBL_W-1:0] == '1) begin
          cnt_nxt   = KW'(MAX_VERTICES);
          acc_nxt   = '0;
          state_nxt = S_P3_RD;
        end else begin
          cnt_nxt   = cnt_inc;
          state_nxt = S_P2_RD;
        end
      end
      S_P2_HW: begin
        h_we = 1'b1;
        h_wa = k_r;
        h_wd = SW'(h_rd + k_r);
        if (cnt_r[LBL_W-1:0] == '1) begin
          cnt_nxt   = KW'(MAX_VERTICES);
          acc_nxt   = '0;
          state_nxt = S_P3_RD;
        end else begin
          cnt_nxt   = cnt_inc;
          state_nxt = S_P2_RD;
        end
      end
      S_P3_RD: state_nxt = S_P3_WT;
      S_P3_WT: begin
        h_we    = 1'b1;
        h_wd    = acc_r;
        acc_nxt = SW'(acc_r + h_rd);
        if (cnt_r == '0) begin
          state_nxt = (n_w != '0) ? S_P4_RD : S_FIN;
        end else begin
          cnt_nxt   = cnt_r - KW'(1);
          state_nxt = S_P3_RD;
        end
      end
      S_P4_RD: state_nxt = S_P4_WT;
      S_P4_WT: begin
        lab_nxt = l_rd[LBL_W-1:0];
        s_ra    = l_rd[LBL_W-1:0];
        if (elig && r_rd == '0) begin
          state_nxt = S_P4_SZ;
        end else begin
          cnt_nxt   = (cnt_inc == n_w) ? '0 : cnt_inc;
          state_nxt = (cnt_inc == n_w) ? S_FIN : S_P4_RD;
        end
      end
      S_P4_SZ: begin
        k_nxt     = s_rd;
        h_ra      = s_rd;
        state_nxt = S_P4_HW;
      end
      S_P4_HW: begin
        o_we = 1'b1;
        h_we = 1'b1;
        h_wa = k_r;
        h_wd = SW'(h_rd + k_r);
        cnt_nxt   = (cnt_inc == n_w) ? '0 : cnt_inc;
        state_nxt = (cnt_inc == n_w) ? S_FIN : S_P4_RD;
      end
      S_FIN: begin
        if (KW'(acc_r) <= KW'(cfg.end_base)) begin
          end_nxt   = POS_W'(KW'(cfg.end_base) - KW'(acc_r));
          under_nxt = 1'b0;
        end else begin
          end_nxt   = '0;
          under_nxt = 1'b1;
        end
        ov_nxt    = 1'b1;
        state_nxt = S_Q_RD;
      end
      S_Q_RD: begin
        l_ra = qidx_r[VW-1:0];
        r_ra = qidx_r[VW-1:0];
        if (qidx_r < n_w) begin
          state_nxt = S_Q_WT;
        end else begin
          res_nxt   = '{placed: 1'b0, slot: '0, new_spoke_end: end_r, underflow: under_r};
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_WT: begin
        rank_nxt = r_rd;
        if (elig) begin
          state_nxt = S_Q_OF;
        end else begin
          res_nxt   = '{placed: 1'b0, slot: '0, new_spoke_end: end_r, underflow: under_r};
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_OF: begin
        res_nxt = '{placed: 1'b1, slot: 12'(end_r[LBL_W-1:0] + o_rd + rank_r),
                    new_spoke_end: end_r, underflow: under_r};
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_hold) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cfg_wr) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      end_r   <= '0;
      under_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      end_r   <= end_nxt;
      under_r <= under_nxt;
    end
  end

  always_ff @(posedge clk) begin
    qidx_r <= qidx_nxt;
    lab_r  <= lab_nxt;
    k_r    <= k_nxt;
    acc_r  <= acc_nxt;
    rank_r <= rank_nxt;
    res_r  <= res_nxt;
  end

endmodule

@@ rtl/core/spoke_order_assigner_core.sv @@
// Load: taken while idle; an index below MAX_VERTICES is written to the vertex store.
// Query with current tables: S_Q_RD, S_Q_WT, S_Q_OF (eligible vertices only), S_Q_OUT (held
// while the output stalls), then out_valid is registered; no request is taken until S_IDLE.
// First query after a load or register write rebuilds the spoke tables first: clear, size
// count, size histogram, prefix sums, offsets and spoke end; then the query states run.
// Reset clears control and registers to defaults; vertex stores hold garbage until loaded.
module spoke_order_assigner_core #(
  parameter int MAX_VERTICES = soa_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  soa_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output soa_pkg::out_rsp_t out_rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_wdata
);
  import soa_pkg::*;

  `include "spoke_order_assigner_core_assert.svh"

  cfg_t     cfg_r, cfg_nxt;
  logic     cfg_wr;
  logic     out_valid_r, out_valid_nxt;
  out_rsp_t out_rsp_r;
  logic     res_vld;
  out_rsp_t res;
  stat_t    stat;

  assign cfg_ready = 1'b1;
  assign cfg_wr = cfg_valid && cfg_ready &&
                  (cfg_index == REG_GIANT || cfg_index == REG_SPOKE_END ||
                   cfg_index == REG_VCOUNT);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_GIANT:     cfg_nxt.giant    = cfg_wdata[LBL_W-1:0];
        REG_SPOKE_END: cfg_nxt.end_base = cfg_wdata;
        REG_VCOUNT:    cfg_nxt.vcount   = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_valid_nxt = res_vld ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '{giant: GIANT_RST, end_base: SPOKE_END_RST, vcount: VCOUNT_RST};
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_vld) begin
      out_rsp_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  soa_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .cfg      (cfg_r),
    .cfg_wr   (cfg_wr),
    .out_hold (out_valid_r && out_stall),
    .res_vld  (res_vld),
    .res      (res),
    .stat     (stat)
  );

  `SOA_ASSERT_IMP(a_no_overwrite, res_vld, !(out_valid_r && out_stall), "result overwrites held output")
  `SOA_ASSERT_NXT(a_query_busy, in_valid && !in_stall && in_req.kind == KIND_QUERY, stat.busy, "engine idle after query")
  `SOA_ASSERT_NXT(a_cfg_invalidates, cfg_wr, !stat.order_valid, "register write left tables valid")

endmodule

@@ tb/soa_scoreboard.sv @@
// Spoke order scoreboard: predicts query responses and checks them in order.
// Depends on soa_pkg for the request and response types and register indexes.
`timescale 1ns / 100ps

class soa_scoreboard;
  bit [11:0] vtx_label [4096];
  bit        vtx_assigned [4096];
  bit [11:0] giant;
  bit [12:0] end_base;
  bit [12:0] vcount;
  bit        tables_ok;
  int        spoke_len [4096];
  int        spoke_head [4096];
  int        spoke_base [4096];
  int        end_pos;
  bit        under;
  soa_pkg::out_rsp_t rsp_q [$];
  int        errors;

  function new();
    giant     = soa_pkg::GIANT_RST;
    end_base  = soa_pkg::SPOKE_END_RST;
    vcount    = soa_pkg::VCOUNT_RST;
    tables_ok = 0;
    errors    = 0;
  endfunction

  function int used_vertices();
    return (vcount > 4096) ? 4096 : int'(vcount);
  endfunction

  function bit in_spoke(int v);
    return !vtx_assigned[v] && vtx_label[v] != giant;
  endfunction

  function void order_spokes();
    int n;
    int total;
    int above;
    int t;
    int k;
    int c;
    int larger [4097];
    int seen [4097];
    n = used_vertices();
    total = 0;
    above = 0;
    for (int s = 0; s < 4096; s++) begin
      spoke_len[s]  = 0;
      spoke_head[s] = 12'hFFF;
      spoke_base[s] = 0;
    end
    for (int s = 0; s <= 4096; s++) begin
      larger[s] = 0;
      seen[s]   = 0;
    end
    for (int v = 0; v < n; v++) begin
      if (in_spoke(v)) begin
        c = vtx_label[v];
        if (spoke_len[c] == 0) spoke_head[c] = v;
        spoke_len[c]++;
        total++;
      end
    end
    for (int s = 0; s < 4096; s++)
      if (spoke_len[s] != 0) larger[spoke_len[s]] += spoke_len[s];
    for (int s = 4096; s >= 0; s--) begin
      t = larger[s];
      larger[s] = above;
      above += t;
    end
    for (int v = 0; v < n; v++) begin
      if (in_spoke(v)) begin
        c = vtx_label[v];
        if (spoke_head[c] == v) begin
          k = spoke_len[c];
          spoke_base[c] = larger[k] + seen[k] * k;
          seen[k]++;
        end
      end
    end
    if (total <= end_base) begin
      end_pos = end_base - total;
      under   = 0;
    end else begin
      end_pos = 0;
      under   = 1;
    end
    tables_ok = 1;
  endfunction

  function void write_reg(logic [1:0] idx, logic [12:0] data);
    case (idx)
      soa_pkg::REG_GIANT:     giant = data[11:0];
      soa_pkg::REG_SPOKE_END: end_base = data;
      soa_pkg::REG_VCOUNT:    vcount = data;
      default: return;
    endcase
    tables_ok = 0;
  endfunction

  function void note_request(soa_pkg::in_req_t r);
    soa_pkg::out_rsp_t e;
    int idx;
    int c;
    int rank;
    idx = r.vertex_index;
    if (r.kind == soa_pkg::KIND_LOAD) begin
      vtx_label[idx]    = r.vertex_label;
      vtx_assigned[idx] = r.already_assigned;
      tables_ok = 0;
      return;
    end
    if (!tables_ok) order_spokes();
    e = '0;
    if (idx < used_vertices() && in_spoke(idx)) begin
      c = vtx_label[idx];
      rank = 0;
      for (int u = spoke_head[c]; u < idx; u++)
        if (in_spoke(u) && vtx_label[u] == c) rank++;
      e.placed = 1;
      e.slot   = 12'(end_pos + spoke_base[c] + rank);
    end
    e.new_spoke_end = 13'(end_pos);
    e.underflow     = under;
    rsp_q.push_back(e);
  endfunction

  function void check_result(soa_pkg::out_rsp_t a);
    soa_pkg::out_rsp_t e;
    if (rsp_q.size() == 0) begin
      $error("unexpected response %h", a);
      errors++;
      return;
    end
    e = rsp_q.pop_front();
    if (a.placed !== e.placed) begin
      $error("placed: expected %0d actual %0d", e.placed, a.placed);
      errors++;
    end
    if (a.slot !== e.slot) begin
      $error("slot: expected %0d actual %0d", e.slot, a.slot);
      errors++;
    end
    if (a.new_spoke_end !== e.new_spoke_end) begin
      $error("new_spoke_end: expected %0d actual %0d", e.new_spoke_end, a.new_spoke_end);
      errors++;
    end
    if (a.underflow !== e.underflow) begin
      $error("underflow: expected %0d actual %0d", e.underflow, a.underflow);
      errors++;
    end
  endfunction
endclass

@@ tb/tb_spoke_order_assigner_core.sv @@
// Top of the spoke order assigner regression: drives loads, queries and register writes.
// Depends on soa_pkg, soa_scoreboard and the spoke_order_assigner_core RTL.
`timescale 1ns / 100ps

module tb_spoke_order_assigner_core;
  import soa_pkg::*;

  localparam int QUIET_LIMIT = 400000;
  localparam int FILL_N      = 64;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_req_t     in_req;
  logic        out_valid;
  logic        out_stall;
  out_rsp_t    out_rsp;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_wdata;

  soa_scoreboard sb;
  bit  calm;
  bit  hold_req;
  int  quiet;

  spoke_order_assigner_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (out_valid && !out_stall) sb.check_result(out_rsp);
    end
  end

  initial begin
    out_stall = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (400) @(negedge clk);
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end
  end

  task automatic send(in_req_t r);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_req   <= r;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic load(int idx, int lbl, bit asg);
    in_req_t r;
    r.kind             = KIND_LOAD;
    r.vertex_index     = 12'(idx);
    r.vertex_label     = 12'(lbl);
    r.already_assigned = asg;
    send(r);
  endtask

  task automatic query(int idx);
    in_req_t r;
    r.kind             = KIND_QUERY;
    r.vertex_index     = 12'(idx);
    r.vertex_label     = 12'($urandom);
    r.already_assigned = 1'($urandom);
    send(r);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.rsp_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic int pick_label();
    return ($urandom_range(9) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(7));
  endfunction

  initial begin
    int n;
    int vc;
    sb = new();
    calm = 0;
    hold_req = 0;
    quiet = 0;
    rst_n = 0;
    in_valid = 0;
    in_req = '0;
    cfg_valid = 0;
    cfg_index = REG_GIANT;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // fill every store entry below the vertex count so no query ever reads garbage
    write_reg(REG_VCOUNT, 13'(FILL_N));
    for (int v = 0; v < FILL_N; v++) load(v, pick_label(), $urandom_range(3) == 0);

    load(0, 0, 0);
    load(FILL_N - 1, 4095, 1);
    load(1, 4095, 0);
    load(2, 4095, 0);
    query(0);
    query(1);
    query(2);
    query(FILL_N - 1);
    query(4095);
    drain();
    write_reg(REG_SPOKE_END, 13'd0);
    write_reg(REG_GIANT, 13'd4095);
    query(0);
    query(3);
    drain();
    write_reg(REG_VCOUNT, 13'd0);
    write_reg(REG_SPOKE_END, 13'd4096);
    query(0);
    drain();
    write_reg(REG_VCOUNT, 13'd1);
    write_reg(REG_GIANT, 13'd0);
    query(0);
    query(1);
    drain();

    for (int p = 0; p < 12; p++) begin
      calm = (p == 6);
      case ($urandom_range(3))
        0: vc = FILL_N;
        1: vc = 1;
        default: vc = $urandom_range(FILL_N, 2);
      endcase
      write_reg(REG_VCOUNT, 13'(vc));
      write_reg(REG_GIANT, 13'(($urandom_range(4) == 0) ? 4095 : $urandom_range(7)));
      case ($urandom_range(3))
        0: write_reg(REG_SPOKE_END, 13'd0);
        1: write_reg(REG_SPOKE_END, 13'd4096);
        2: write_reg(REG_SPOKE_END, 13'($urandom_range(vc / 2)));
        default: write_reg(REG_SPOKE_END, 13'($urandom_range(4096)));
      endcase
      n = vc;
      for (int i = 0; i < 10; i++)
        load(($urandom_range(7) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(n - 1)),
             pick_label(), $urandom_range(3) == 0);
      if (p == 3) hold_req = 1;
      for (int i = 0; i < 20; i++) begin
        if (p % 5 == 2 && i == 12) load($urandom_range(n - 1), pick_label(), $urandom_range(1));
        query(($urandom_range(5) == 0) ? int'($urandom_range(4095)) : int'($urandom_range(n - 1)));
      end
      drain();
    end

    calm = 0;
    drain();
    repeat (50) @(negedge clk);
    if (sb.errors == 0 && sb.rsp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/soa_pkg.sv
rtl/core/soa_ram.sv
rtl/core/soa_engine.sv
rtl/core/spoke_order_assigner_core.sv
tb/soa_scoreboard.sv
tb/tb_spoke_order_assigner_core.sv
